// ----- hdl/trma_pkg.sv -----
// Shared constants, register codes and types for the timer reload and ms accumulator.
`default_nettype none
package trma_pkg;

  // Default configuration of the base clock and the request limits.
  localparam int BASE_CLOCK_HZ_DEF        = 1193182;
  localparam int LOW_FREQUENCY_LIMIT_DEF  = 18;
  localparam int HIGH_FREQUENCY_LIMIT_DEF = 65535;

  // Field widths fixed by the interface.
  localparam int FREQ_W   = 16;
  localparam int DIV_W    = 17;
  localparam int ACT_W    = 21;
  localparam int PMS_W    = 6;
  localparam int WORD_W   = 32;

  // Fixed-point period arithmetic: divisor * MS_FACTOR >> MS_SHIFT is 32.32 ms.
  localparam logic [DIV_W-1:0]  MAX_DIVISOR = 17'h10000;
  localparam logic [WORD_W-1:0] MS_FACTOR   = 32'hDBB3A062;
  localparam int                MS_SHIFT    = 10;
  localparam int                PROD_W      = DIV_W + WORD_W;

  // Configuration register index (byte address bit 2).
  typedef enum logic {
    REG_REQUESTED_FREQUENCY = 1'b0
  } reg_index_t;

  // Request to the shared rounding divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ----- hdl/trma_div.sv -----
// Shared bit-serial rounding divider: constant numerator over a 17-bit divisor.
`default_nettype none
module trma_div #(
  parameter int NUM = trma_pkg::BASE_CLOCK_HZ_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire trma_pkg::div_req_t         req,
  output logic                            busy,
  output logic                            done,
  output logic [$clog2(NUM + 1):0]        quotient
);
  import trma_pkg::*;

  localparam int NUM_W = $clog2(NUM + 1);
  localparam int QW    = NUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] NUM_BITS  = NUM_W'(NUM);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic             round_up;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      cnt    <= CNT_START;
      num_sh <= NUM_BITS;
      quo    <= '0;
      rem    <= '0;
      dvs    <= req.divisor;
    end else if (busy) begin
      cnt    <= cnt - CNT_LAST;
      num_sh <= num_sh << 1;
      if (fits) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Round up when the remainder reaches the integer half of the divisor.
  assign round_up = rem >= (dvs >> 1);
  assign quotient = QW'(quo) + QW'(round_up);

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("divider did not start");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CNT_LAST) |=> done)
    else $error("divider missed its done pulse");
`endif

endmodule
`default_nettype wire

// ----- hdl/timer_reload_and_ms_accumulator.sv -----
// Top level: timer reload divisor, actual rate, period and elapsed-time accumulator.
`default_nettype none
// The block turns the requested interrupt rate in requested_frequency into a
// reload divisor of BASE_CLOCK_HZ, rounded up when the remainder reaches the
// integer half of the divisor (rounded down), clamped to 65536 for requests at or
// below LOW_FREQUENCY_LIMIT and forced to 1 at or above HIGH_FREQUENCY_LIMIT.
// It then derives the rounded actual rate and the 32.32 milliseconds per
// period (divisor times 0xDBB3A062, shifted right by 10). Every slave
// transaction carries one tick bit; a set bit adds the period to the 32.32
// elapsed-time total, whose millisecond part wraps modulo 2^32. Each slave
// transaction yields exactly one master transaction with the totals after
// the update and the derived timer values. Both divisions run through one
// shared divider that retires one quotient bit per cycle; the first is
// followed by a hand-over state, and a multiply step and an accumulate
// step come after the second. A request that hits either clamp skips the
// first division. Only once the sequencer is back in idle is the next slave
// transaction taken, so a new item waits until the last one is through.
// A finished result sits in an output register, so the next slave
// transaction is taken while the previous result still waits; only when that
// result is still waiting at the accumulate step does the sequencer hold
// there. Write the configuration register only while no item is in flight.
module timer_reload_and_ms_accumulator #(
  parameter int BASE_CLOCK_HZ        = trma_pkg::BASE_CLOCK_HZ_DEF,
  parameter int LOW_FREQUENCY_LIMIT  = trma_pkg::LOW_FREQUENCY_LIMIT_DEF,
  parameter int HIGH_FREQUENCY_LIMIT = trma_pkg::HIGH_FREQUENCY_LIMIT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Slave stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [0] tick, [7:1] zero
  // Master stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,   // [31:0] elapsed_ms, [63:32] elapsed_fraction,
                                       // [80:64] reload_divisor, [101:81] actual_frequency,
                                       // [107:102] period_ms, [139:108] period_fraction,
                                       // [143:140] zero
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import trma_pkg::*;

  localparam int NUM_W = $clog2(BASE_CLOCK_HZ + 1);
  localparam int QW    = NUM_W + 1;
  localparam logic [FREQ_W-1:0] LOW_LIM  = FREQ_W'(LOW_FREQUENCY_LIMIT);
  localparam logic [FREQ_W-1:0] HIGH_LIM = FREQ_W'(HIGH_FREQUENCY_LIMIT);
  localparam logic [DIV_W-1:0]  ONE_DIV  = DIV_W'(1);

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV_F   = 6'b000010,
    ST_START_D = 6'b000100,
    ST_DIV_D   = 6'b001000,
    ST_MUL     = 6'b010000,
    ST_ACC     = 6'b100000
  } state_t;

  state_t state;

  // Configuration.
  logic [FREQ_W-1:0] requested_frequency;
  reg_index_t        reg_sel;

  // Work registers.
  logic              tick;
  logic [DIV_W-1:0]  divisor;
  logic [ACT_W-1:0]  actual;
  logic [PMS_W-1:0]  p_ms;
  logic [WORD_W-1:0] p_frac;

  // Elapsed-time totals.
  logic [WORD_W-1:0] ms_total;
  logic [WORD_W-1:0] fraction_total;

  // Output register.
  logic [WORD_W-1:0] out_ms;
  logic [WORD_W-1:0] out_frac;
  logic [DIV_W-1:0]  out_divisor;
  logic [ACT_W-1:0]  out_actual;
  logic [PMS_W-1:0]  out_p_ms;
  logic [WORD_W-1:0] out_p_frac;

  // Shared divider.
  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [QW-1:0]     div_quo;

  logic              accept;
  logic              freq_low;
  logic              freq_high;
  logic [PROD_W-1:0] product;
  logic [WORD_W:0]   frac_sum;
  logic [WORD_W-1:0] ms_total_next;
  logic              out_free;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access cycle; reads are
  // combinational from the register.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_frequency <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_REQUESTED_FREQUENCY: requested_frequency <= pwdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REQUESTED_FREQUENCY: prdata = 32'(requested_frequency);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request classification. The low clamp wins over the high one when the
  // limits overlap, and zero always counts as a low request.
  // ---------------------------------------------------------------------
  assign freq_low  = (requested_frequency <= LOW_LIM) || (requested_frequency == '0);
  assign freq_high = requested_frequency >= HIGH_LIM;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // The divider first computes BASE / requested rate, then BASE / divisor.
  always_comb begin
    div_req.start   = 1'b0;
    div_req.divisor = divisor;
    if (state == ST_IDLE) begin
      div_req.start   = accept && !freq_low && !freq_high;
      div_req.divisor = DIV_W'(requested_frequency);
    end else if (state == ST_START_D) begin
      div_req.start   = 1'b1;
    end
  end

  trma_div #(
    .NUM (BASE_CLOCK_HZ)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Period in 32.32 ms: the integer part never exceeds six bits.
  assign product = PROD_W'(divisor) * PROD_W'(MS_FACTOR);

  // Accumulate: fraction carry goes into the millisecond count.
  assign frac_sum      = {1'b0, fraction_total} + {1'b0, p_frac};
  assign ms_total_next = ms_total + WORD_W'(p_ms) + WORD_W'(frac_sum[WORD_W]);
  assign out_free      = !m_tvalid || m_tready;

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (freq_low || freq_high) begin
              state <= ST_START_D;
            end else begin
              state <= ST_DIV_F;
            end
          end
        end
        ST_DIV_F: begin
          if (div_done) begin
            state <= ST_START_D;
          end
        end
        ST_START_D: state <= ST_DIV_D;
        ST_DIV_D: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Work registers of the current item.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick <= s_tdata[0];
      if (freq_low) begin
        divisor <= MAX_DIVISOR;
      end else if (freq_high) begin
        divisor <= ONE_DIV;
      end
    end
    if (state == ST_DIV_F && div_done) begin
      // Saturate the rounded quotient into 1 .. 65536.
      if (32'(div_quo) > 32'(MAX_DIVISOR)) begin
        divisor <= MAX_DIVISOR;
      end else if (div_quo == '0) begin
        divisor <= ONE_DIV;
      end else begin
        divisor <= DIV_W'(div_quo);
      end
    end
    if (state == ST_DIV_D && div_done) begin
      actual <= ACT_W'(div_quo);
    end
    if (state == ST_MUL) begin
      p_ms   <= product[MS_SHIFT+WORD_W+PMS_W-1:MS_SHIFT+WORD_W];
      p_frac <= product[MS_SHIFT+WORD_W-1:MS_SHIFT];
    end
  end

  // Totals and the output register. A new result replaces the one that is
  // leaving in the same cycle, so valid simply stays high then.
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_total       <= '0;
      fraction_total <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (state == ST_ACC && out_free) begin
        m_tvalid <= 1'b1;
        if (tick) begin
          ms_total       <= ms_total_next;
          fraction_total <= frac_sum[WORD_W-1:0];
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACC && out_free) begin
      out_ms      <= tick ? ms_total_next : ms_total;
      out_frac    <= tick ? frac_sum[WORD_W-1:0] : fraction_total;
      out_divisor <= divisor;
      out_actual  <= actual;
      out_p_ms    <= p_ms;
      out_p_frac  <= p_frac;
    end
  end

  assign m_tdata = {4'b0000, out_p_frac, out_p_ms, out_actual, out_divisor, out_frac, out_ms};

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_F || state == ST_DIV_D))
    else $error("divider result outside a wait state");
  a_divisor_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (divisor != '0 && divisor <= MAX_DIVISOR))
    else $error("reload divisor out of range");
  a_ready_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("ready while the divider is busy");
`endif

endmodule
`default_nettype wire
